// ----- hdl/jsu_pkg.sv -----
package jsu_pkg;

  localparam int RUN_MAX = 4;
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);
  localparam int RUN_IDX_W = $clog2(RUN_MAX);

  typedef enum logic [2:0] {
    MODE_IDLE          = 3'd0,
    MODE_BODY          = 3'd1,
    MODE_ESC           = 3'd2,
    MODE_HEX           = 3'd3,
    MODE_AFTER_HIGH    = 3'd4,
    MODE_AFTER_HIGH_BS = 3'd5,
    MODE_LOW_HEX       = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DATA  = 2'd0,
    STAT_DONE  = 2'd1,
    STAT_ERROR = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ERR_NO_QUOTE       = 4'd0,
    ERR_TRUNC_ESC      = 4'd1,
    ERR_TRUNC_HEX      = 4'd2,
    ERR_BAD_HEX        = 4'd3,
    ERR_LONE_HIGH      = 4'd4,
    ERR_LONE_LOW       = 4'd5,
    ERR_UNKNOWN_ESC    = 4'd6,
    ERR_CONTROL_CHAR   = 4'd7,
    ERR_UNTERMINATED   = 4'd8
  } err_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_marker;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic [3:0] error_code;
    logic       last_of_run;
  } jsu_out_t;

  // results produced by one request
  typedef struct packed {
    logic [RUN_CNT_W-1:0]      cnt;
    logic [RUN_MAX-1:0][7:0]   bytes;
    status_t                   status;
    err_t                      err;
  } jsu_run_t;

endpackage

// ----- hdl/json_string_unescape_utf8.sv -----
// Channel  Ports                              Moves
// in       in_valid in_ready in_data          one raw byte or end marker per request
// out      out_valid out_ready out_data       one UTF-8 byte, completion or error
//
// A request is decoded from the input register once the run register is free, and
// its results (up to four) are loaded into the run register together.
// Results leave one per cycle while out_ready is high; a request holds the run
// register until its last result leaves, so requests of at most one result keep that rate.
// Reset (rst_n low, synchronous) returns the decoder to awaiting an opening quote.
// A stalled output holds the run and the input register; in_ready falls once that register is full.
module json_string_unescape_utf8 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jsu_pkg::jsu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output jsu_pkg::jsu_out_t out_data
);
  import jsu_pkg::*;

  logic     in_vld_r;
  jsu_in_t  in_item_r;
  logic     run_free;
  logic     fire;
  jsu_run_t run;

  assign fire     = in_vld_r && run_free;
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  jsu_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .run   (run)
  );

  jsu_out_run u_out_run (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .run       (run),
    .run_free  (run_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/jsu_decode.sv -----
module jsu_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  jsu_pkg::jsu_in_t item,
  output jsu_pkg::jsu_run_t run
);
  import jsu_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic        bad_r, bad_nxt;
  logic [9:0]  hs_r, hs_nxt;

  logic [7:0]  b;
  logic        eom;
  logic        dok;
  logic [3:0]  dval;
  logic [15:0] acc_take;
  logic        bad_take;
  logic        fourth;
  logic [20:0] cp;
  logic [RUN_CNT_W-1:0]    enc_cnt;
  logic [RUN_MAX-1:0][7:0] enc_bytes;

  assign b   = item.in_byte;
  assign eom = item.end_marker;

  always_comb begin
    dok  = 1'b1;
    dval = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      dval = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      dval = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      dval = 4'(b - 8'h37);
    end else begin
      dok = 1'b0;
    end
  end

  assign acc_take = {acc_r[11:0], dval};
  assign bad_take = bad_r | ~dok;
  assign fourth   = (dcnt_r == 2'd3);

  assign cp = (mode_r == MODE_LOW_HEX) ? 21'h10000 + {1'b0, hs_r, acc_take[9:0]}
                                       : {5'b0, acc_take};

  // UTF-8 encoder
  always_comb begin
    enc_bytes = '0;
    if (cp < 21'h80) begin
      enc_cnt      = RUN_CNT_W'(1);
      enc_bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      enc_cnt      = RUN_CNT_W'(2);
      enc_bytes[0] = {3'b110, cp[10:6]};
      enc_bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      enc_cnt      = RUN_CNT_W'(3);
      enc_bytes[0] = {4'b1110, cp[15:12]};
      enc_bytes[1] = {2'b10, cp[11:6]};
      enc_bytes[2] = {2'b10, cp[5:0]};
    end else begin
      enc_cnt      = RUN_CNT_W'(4);
      enc_bytes[0] = {5'b11110, cp[20:18]};
      enc_bytes[1] = {2'b10, cp[17:12]};
      enc_bytes[2] = {2'b10, cp[11:6]};
      enc_bytes[3] = {2'b10, cp[5:0]};
    end
  end

  always_comb begin
    logic   fail;
    err_t   ferr;
    fail       = 1'b0;
    ferr       = ERR_NO_QUOTE;
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    dcnt_nxt   = dcnt_r;
    bad_nxt    = bad_r;
    hs_nxt     = hs_r;
    run.cnt    = '0;
    run.bytes  = '0;
    run.status = STAT_DATA;
    run.err    = ERR_NO_QUOTE;

    case (mode_r)
      MODE_BODY: begin
        if (eom) begin
          fail = 1'b1;
          ferr = ERR_UNTERMINATED;
        end else if (b == CH_QUOTE) begin
          run.cnt    = RUN_CNT_W'(1);
          run.status = STAT_DONE;
          mode_nxt   = MODE_IDLE;
        end else if (b == CH_BACKSLASH) begin
          mode_nxt = MODE_ESC;
        end else if (b < CH_SPACE) begin
          fail = 1'b1;
          ferr = ERR_CONTROL_CHAR;
        end else begin
          run.cnt      = RUN_CNT_W'(1);
          run.bytes[0] = b;
        end
      end
      MODE_ESC: begin
        if (eom) begin
          fail = 1'b1;
          ferr = ERR_TRUNC_ESC;
        end else begin
          mode_nxt = MODE_BODY;
          run.cnt  = RUN_CNT_W'(1);
          case (b)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: run.bytes[0] = b;
            CH_B: run.bytes[0] = 8'h08;
            CH_F: run.bytes[0] = 8'h0C;
            CH_N: run.bytes[0] = 8'h0A;
            CH_R: run.bytes[0] = 8'h0D;
            CH_T: run.bytes[0] = 8'h09;
            CH_U: begin
              run.cnt  = '0;
              mode_nxt = MODE_HEX;
              acc_nxt  = '0;
              dcnt_nxt = '0;
              bad_nxt  = 1'b0;
            end
            default: begin
              fail = 1'b1;
              ferr = ERR_UNKNOWN_ESC;
            end
          endcase
        end
      end
      MODE_HEX, MODE_LOW_HEX: begin
        if (eom) begin
          fail = 1'b1;
          ferr = ERR_TRUNC_HEX;
        end else begin
          acc_nxt  = acc_take;
          bad_nxt  = bad_take;
          dcnt_nxt = fourth ? 2'd0 : dcnt_r + 2'd1;
          if (fourth) begin
            if (bad_take) begin
              fail = 1'b1;
              ferr = ERR_BAD_HEX;
            end else if (mode_r == MODE_HEX) begin
              if (acc_take[15:10] == 6'b110110) begin
                hs_nxt   = acc_take[9:0];
                mode_nxt = MODE_AFTER_HIGH;
              end else if (acc_take[15:10] == 6'b110111) begin
                fail = 1'b1;
                ferr = ERR_LONE_LOW;
              end else begin
                mode_nxt  = MODE_BODY;
                run.cnt   = enc_cnt;
                run.bytes = enc_bytes;
              end
            end else begin
              if (acc_take[15:10] != 6'b110111) begin
                fail = 1'b1;
                ferr = ERR_LONE_HIGH;
              end else begin
                mode_nxt  = MODE_BODY;
                run.cnt   = enc_cnt;
                run.bytes = enc_bytes;
              end
            end
          end
        end
      end
      MODE_AFTER_HIGH: begin
        if (eom || b != CH_BACKSLASH) begin
          fail = 1'b1;
          ferr = ERR_LONE_HIGH;
        end else begin
          mode_nxt = MODE_AFTER_HIGH_BS;
        end
      end
      MODE_AFTER_HIGH_BS: begin
        if (eom || b != CH_U) begin
          fail = 1'b1;
          ferr = ERR_LONE_HIGH;
        end else begin
          mode_nxt = MODE_LOW_HEX;
          acc_nxt  = '0;
          dcnt_nxt = '0;
          bad_nxt  = 1'b0;
        end
      end
      default: begin
        if (eom || b != CH_QUOTE) begin
          fail = 1'b1;
          ferr = ERR_NO_QUOTE;
        end else begin
          mode_nxt = MODE_BODY;
        end
      end
    endcase

    if (fail) begin
      run.cnt    = RUN_CNT_W'(1);
      run.bytes  = '0;
      run.status = STAT_ERROR;
      run.err    = ferr;
      mode_nxt   = MODE_IDLE;
      acc_nxt    = '0;
      dcnt_nxt   = '0;
      bad_nxt    = 1'b0;
      hs_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      dcnt_r <= '0;
      bad_r  <= 1'b0;
      hs_r   <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      dcnt_r <= dcnt_nxt;
      bad_r  <= bad_nxt;
      hs_r   <= hs_nxt;
    end
  end

endmodule

// ----- hdl/jsu_out_run.sv -----
module jsu_out_run (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  jsu_pkg::jsu_run_t run,
  output logic              run_free,
  output logic              out_valid,
  input  logic              out_ready,
  output jsu_pkg::jsu_out_t out_data
);
  import jsu_pkg::*;

  logic [RUN_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [RUN_IDX_W-1:0]    idx_r, idx_nxt;
  logic [RUN_MAX-1:0][7:0] bytes_r;
  status_t                 status_r;
  err_t                    err_r;
  logic                    last;
  logic                    pop;

  assign out_valid = (cnt_r != '0);
  assign last      = (RUN_CNT_W'(idx_r) + RUN_CNT_W'(1) == cnt_r);
  assign pop       = out_valid && out_ready;
  assign run_free  = !out_valid || (pop && last);

  assign out_data.out_byte    = bytes_r[idx_r];
  assign out_data.status      = status_r;
  assign out_data.error_code  = err_r;
  assign out_data.last_of_run = last;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = run.cnt;
      idx_nxt = '0;
    end else if (pop) begin
      if (last) begin
        cnt_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + RUN_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r  <= run.bytes;
      status_r <= run.status;
      err_r    <= run.err;
    end
  end

endmodule

// ----- bench/json_string_unescape_utf8_tb.sv -----
module json_string_unescape_utf8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 410;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = 8;

  class unescape_scoreboard;
    mode_t        mode;
    logic [15:0]  hex_acc;
    logic [1:0]   digit_cnt;
    logic         bad_digit;
    logic [9:0]   high_bits;
    jsu_out_t     run_q[$];
    jsu_out_t     utf8_due[$];
    int           requests;
    int           data_bytes;
    int           strings_closed;
    int           errors_flagged;
    int           fails;
    logic [8:0]   codes_hit;

    function new();
      clear_state();
      requests = 0;
      data_bytes = 0;
      strings_closed = 0;
      errors_flagged = 0;
      fails = 0;
      codes_hit = '0;
    endfunction

    function void clear_state();
      mode = MODE_IDLE;
      hex_acc = '0;
      digit_cnt = '0;
      bad_digit = 1'b0;
      high_bits = '0;
    endfunction

    function void emit(logic [7:0] b, status_t st = STAT_DATA, logic [3:0] code = '0);
      jsu_out_t r;
      r.out_byte = b;
      r.status = st;
      r.error_code = code;
      r.last_of_run = 1'b0;
      run_q.push_back(r);
    endfunction

    function void abort_string(err_t code);
      emit(8'h00, STAT_ERROR, code);
      clear_state();
    endfunction

    function void start_digits(mode_t next_mode);
      mode = next_mode;
      hex_acc = '0;
      digit_cnt = '0;
      bad_digit = 1'b0;
    endfunction

    // returns 1 on the fourth digit
    function bit take_digit(logic [7:0] b);
      logic [3:0] d;
      if (b >= "0" && b <= "9") d = 4'(b - "0");
      else if (b >= "a" && b <= "f") d = 4'(b - "a" + 8'd10);
      else if (b >= "A" && b <= "F") d = 4'(b - "A" + 8'd10);
      else begin
        d = '0;
        bad_digit = 1'b1;
      end
      hex_acc = {hex_acc[11:0], d};
      if (digit_cnt == 2'd3) begin
        digit_cnt = '0;
        return 1'b1;
      end
      digit_cnt = digit_cnt + 2'd1;
      return 1'b0;
    endfunction

    function void utf8_encode(logic [20:0] cp);
      if (cp < 21'h80) begin
        emit(cp[7:0]);
      end else if (cp < 21'h800) begin
        emit({3'b110, cp[10:6]});
        emit({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        emit({4'b1110, cp[15:12]});
        emit({2'b10, cp[11:6]});
        emit({2'b10, cp[5:0]});
      end else begin
        emit({5'b11110, cp[20:18]});
        emit({2'b10, cp[17:12]});
        emit({2'b10, cp[11:6]});
        emit({2'b10, cp[5:0]});
      end
    endfunction

    function void decode_request(jsu_in_t req);
      logic [7:0] b;
      logic       fin;
      b = req.in_byte;
      fin = req.end_marker;
      run_q.delete();
      requests++;
      case (mode)
        MODE_BODY: begin
          if (fin) abort_string(ERR_UNTERMINATED);
          else if (b == CH_QUOTE) begin
            emit(8'h00, STAT_DONE);
            mode = MODE_IDLE;
          end else if (b == CH_BACKSLASH) mode = MODE_ESC;
          else if (b < CH_SPACE) abort_string(ERR_CONTROL_CHAR);
          else emit(b);
        end
        MODE_ESC: begin
          if (fin) abort_string(ERR_TRUNC_ESC);
          else begin
            mode = MODE_BODY;
            case (b)
              CH_QUOTE, CH_BACKSLASH, CH_SLASH: emit(b);
              CH_B: emit(8'h08);
              CH_F: emit(8'h0C);
              CH_N: emit(8'h0A);
              CH_R: emit(8'h0D);
              CH_T: emit(8'h09);
              CH_U: start_digits(MODE_HEX);
              default: abort_string(ERR_UNKNOWN_ESC);
            endcase
          end
        end
        MODE_HEX: begin
          if (fin) abort_string(ERR_TRUNC_HEX);
          else if (take_digit(b)) begin
            if (bad_digit) abort_string(ERR_BAD_HEX);
            else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
              high_bits = hex_acc[9:0];
              mode = MODE_AFTER_HIGH;
            end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
              abort_string(ERR_LONE_LOW);
            end else begin
              mode = MODE_BODY;
              utf8_encode({5'd0, hex_acc});
            end
          end
        end
        MODE_AFTER_HIGH: begin
          if (fin || b != CH_BACKSLASH) abort_string(ERR_LONE_HIGH);
          else mode = MODE_AFTER_HIGH_BS;
        end
        MODE_AFTER_HIGH_BS: begin
          if (fin || b != CH_U) abort_string(ERR_LONE_HIGH);
          else start_digits(MODE_LOW_HEX);
        end
        MODE_LOW_HEX: begin
          if (fin) abort_string(ERR_TRUNC_HEX);
          else if (take_digit(b)) begin
            if (bad_digit) abort_string(ERR_BAD_HEX);
            else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) abort_string(ERR_LONE_HIGH);
            else begin
              mode = MODE_BODY;
              utf8_encode(21'h10000 + {1'b0, high_bits, hex_acc[9:0]});
            end
          end
        end
        default: begin
          if (fin || b != CH_QUOTE) abort_string(ERR_NO_QUOTE);
          else mode = MODE_BODY;
        end
      endcase
      if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
      foreach (run_q[i]) utf8_due.push_back(run_q[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_output(jsu_out_t got);
      jsu_out_t want;
      if (utf8_due.size() == 0) begin
        $display("%0t: unexpected output, expected none, actual byte=%0h status=%0d err=%0d last=%b",
                 $time, got.out_byte, got.status, got.error_code, got.last_of_run);
        fails++;
        return;
      end
      want = utf8_due.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
      compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
      case (want.status)
        STAT_DATA: data_bytes++;
        STAT_DONE: strings_closed++;
        default: begin
          errors_flagged++;
          if (want.error_code <= ERR_UNTERMINATED) codes_hit[want.error_code] = 1'b1;
        end
      endcase
    endfunction
  endclass

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  jsu_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  jsu_out_t out_data;

  unescape_scoreboard board = new();
  int snd_idle_pct;
  int rcv_idle_pct;
  int sent;
  int quiet_cycles;

  json_string_unescape_utf8 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.decode_request(in_data);
      if (out_valid && out_ready) board.check_output(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no request or output moved for %0d cycles", $time, quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_req(jsu_in_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data <= jsu_in_t'(9'($urandom_range(511)));
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    jsu_in_t r;
    r.in_byte = b;
    r.end_marker = 1'b0;
    send_req(r);
  endtask

  task automatic send_end();
    jsu_in_t r;
    r.in_byte = 8'($urandom_range(255));
    r.end_marker = 1'b1;
    send_req(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.utf8_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(1) ? "a" : "A") + n - 8'd10);
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
    return b;
  endfunction

  // first count digits of v, digit at bad_pos replaced by a non-hex byte
  task automatic send_hex_digits(logic [15:0] v, int count, int bad_pos);
    for (int i = 0; i < count; i++) begin
      if (i == bad_pos) send_byte(bad_hex_char());
      else send_byte(hex_char(v[15 - 4 * i -: 4]));
    end
  endtask

  task automatic send_unicode(logic [15:0] v);
    send_byte(CH_BACKSLASH);
    send_byte(CH_U);
    send_hex_digits(v, 4, -1);
  endtask

  task automatic send_element();
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        do b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == CH_QUOTE || b == CH_BACKSLASH);
        send_byte(b);
      end
      4, 5: begin
        send_byte(CH_BACKSLASH);
        case ($urandom_range(7))
          0: send_byte(CH_QUOTE);
          1: send_byte(CH_BACKSLASH);
          2: send_byte(CH_SLASH);
          3: send_byte(CH_B);
          4: send_byte(CH_F);
          5: send_byte(CH_N);
          6: send_byte(CH_R);
          default: send_byte(CH_T);
        endcase
      end
      6, 7: begin
        case ($urandom_range(2))
          0: v = 16'($urandom_range(16'h007F));
          1: v = 16'($urandom_range(16'h0080, 16'h07FF));
          default: begin
            if ($urandom_range(1)) v = 16'($urandom_range(16'h0800, 16'hD7FF));
            else v = 16'($urandom_range(16'hE000, 16'hFFFF));
          end
        endcase
        send_unicode(v);
      end
      default: begin
        send_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
        send_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end
    endcase
  endtask

  // ends the open string with one of the error paths
  task automatic send_broken_tail();
    logic [7:0]  b;
    logic [15:0] v;
    logic        ok;
    case ($urandom_range(9))
      0: send_end();
      1: send_byte(8'($urandom_range(8'h1F)));
      2: begin
        send_byte(CH_BACKSLASH);
        send_end();
      end
      3: begin
        do begin
          b = 8'($urandom_range(255));
          case (b)
            CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: ok = 1'b0;
            default: ok = 1'b1;
          endcase
        end while (!ok);
        send_byte(CH_BACKSLASH);
        send_byte(b);
      end
      4, 5: begin
        if ($urandom_range(1)) begin
          send_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
        end
        send_byte(CH_BACKSLASH);
        send_byte(CH_U);
        if ($urandom_range(1)) begin
          send_hex_digits(16'($urandom), 4, $urandom_range(3));
        end else begin
          send_hex_digits(16'($urandom), $urandom_range(3), $urandom_range(1) ? -1 : 0);
          send_end();
        end
      end
      6: send_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
      7: begin
        send_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
        if ($urandom_range(3) == 0) send_end();
        else begin
          do b = 8'($urandom_range(255));
          while (b == CH_BACKSLASH);
          send_byte(b);
        end
      end
      8: begin
        send_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
        send_byte(CH_BACKSLASH);
        if ($urandom_range(3) == 0) send_end();
        else begin
          do b = 8'($urandom_range(255));
          while (b == CH_U);
          send_byte(b);
        end
      end
      default: begin
        send_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
        do v = 16'($urandom);
        while (v >= 16'hDC00 && v <= 16'hDFFF);
        send_unicode(v);
      end
    endcase
  endtask

  task automatic random_segment();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 8) begin
      if ($urandom_range(3) == 0) send_end();
      else begin
        do b = 8'($urandom_range(255));
        while (b == CH_QUOTE);
        send_byte(b);
      end
    end else begin
      send_byte(CH_QUOTE);
      repeat ($urandom_range(6)) send_element();
      if (pick < 26) send_broken_tail();
      else send_byte(CH_QUOTE);
    end
  endtask

  initial begin
    int base;
    int phase;
    snd_idle_pct = 19;
    rcv_idle_pct = 48;
    sent = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no opening quote: end marker, then a stray byte
    send_end();
    send_byte("x");
    // raw extremes, max supplementary pair, escape, end inside the body
    send_byte(CH_QUOTE);
    send_byte(8'hFF);
    send_byte(CH_SPACE);
    send_unicode(16'hDBFF);
    send_unicode(16'hDFFF);
    send_byte(CH_BACKSLASH);
    send_byte(CH_N);
    send_end();
    // control character
    send_byte(CH_QUOTE);
    send_byte(8'h1F);
    // truncated hex with a bad digit already taken
    send_byte(CH_QUOTE);
    send_byte(CH_BACKSLASH);
    send_byte(CH_U);
    send_hex_digits(16'h0000, 2, 1);
    send_end();
    wait_drained();

    base = sent;
    phase = 0;
    while (sent < base + RANDOM_ITEMS) begin
      if (phase == 0 && sent >= base + RANDOM_ITEMS / 3) begin
        wait_drained();
        snd_idle_pct = 48;
        rcv_idle_pct = 19;
        phase = 1;
      end else if (phase == 1 && sent >= base + 2 * RANDOM_ITEMS / 3) begin
        wait_drained();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        phase = 2;
      end
      random_segment();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.utf8_due.size() != 0) begin
      $display("%0t: %0d expected outputs never arrived", $time, board.utf8_due.size());
      board.fails++;
    end
    $display("decoded %0d requests into %0d UTF-8 bytes, %0d closed strings, %0d errors",
             board.requests, board.data_bytes, board.strings_closed, board.errors_flagged);
    $display("error codes reached (8 down to 0): %b", board.codes_hit);
    if (board.fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
